FILE: hw/rtl/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

  localparam int unsigned SymBits  = 8;
  localparam int unsigned FreqW    = 16;
  localparam int unsigned CodeBits = 31;
  localparam int unsigned LenBits  = 5;

  typedef struct packed {
    logic [SymBits-1:0] symbol;
    logic [FreqW-1:0]   frequency;
    logic               last_symbol;
  } in_word_t;

  typedef struct packed {
    logic [SymBits-1:0]  code_symbol;
    logic [CodeBits-1:0] code_bits;
    logic [LenBits-1:0]  code_length;
    logic                last_code;
  } out_word_t;

  // Datapath commands, one per controller step.
  typedef enum logic [3:0] {
    CMD_NOP     = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_INIT    = 4'd2,
    CMD_SIFT_RD = 4'd3,
    CMD_SIFT_EX = 4'd4,
    CMD_TAKE    = 4'd5,
    CMD_MERGE   = 4'd6,
    CMD_UP_RD   = 4'd7,
    CMD_UP_EX   = 4'd8,
    CMD_WALK_INIT = 4'd9,
    CMD_WALK_RD = 4'd10,
    CMD_WALK_EX = 4'd11,
    CMD_FINISH  = 4'd12
  } cmd_e;

  typedef struct packed {
    logic sift_done;     // current sift step found no swap and no build slot remains
    logic build_done;    // bottom-up build visited node 0
    logic heap_single;   // heap holds at most one node or node store is full
    logic take_second;   // first of the pair already taken
    logic up_done;       // insertion reached its slot
    logic walk_empty;    // walk stack drained
    logic walk_leaf;     // popped node is a leaf
    logic out_full;      // output register holds a word that is stalled
  } status_t;

endpackage

FILE: hw/rtl/hcb_datapath.sv
// Node store, heap, walk stack and output register of the code builder.
module hcb_datapath
  import hcb_pkg::*;
#(
  parameter int unsigned MaxSym   = 32,
  parameter int unsigned FreqBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_e      cmd_i,
  input  in_word_t  in_word_i,
  input  logic      out_stall_i,
  output status_t   status_o,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  localparam int unsigned NodeN = 2 * MaxSym - 1;
  localparam int unsigned NW    = $clog2(NodeN);
  localparam int unsigned HW    = $clog2(MaxSym);
  localparam int unsigned CW    = $clog2(MaxSym + 1);
  localparam int unsigned WW    = FreqBits + $clog2(MaxSym);
  localparam int unsigned SW    = $clog2(MaxSym + 2);
  localparam logic [WW-1:0] FMask = {{(WW-FreqBits){1'b0}}, {FreqBits{1'b1}}};

  logic [WW-1:0]      weight_mem [NodeN];
  logic [NW-1:0]      lchild_mem [NodeN];
  logic [NW-1:0]      rchild_mem [NodeN];
  logic [SymBits-1:0] sym_mem    [MaxSym];
  logic [NW-1:0]      heap_q     [MaxSym];
  logic [NW-1:0]      stk_node_q [MaxSym + 1];
  logic [CodeBits-1:0] stk_code_q [MaxSym + 1];
  logic [LenBits-1:0] stk_len_q  [MaxSym + 1];
  logic [SW-1:0]      stk_sp_q;

  logic [CW-1:0] leaf_cnt_q, heap_cnt_q;
  logic [NW:0]   next_q;
  logic [HW:0]   at_q;
  logic [HW:0]   bld_q;   // heap slot whose sift the bottom-up build is on
  logic          build_q, take2_q;
  logic [NW-1:0] a_q, b_q;
  logic [WW-1:0] wa_q, wl_q, wr_q;
  logic          lok_q, rok_q;
  logic [NW-1:0] pop_node_q;
  logic [CodeBits-1:0] pop_code_q;
  logic [LenBits-1:0]  pop_len_q;
  logic          out_v_q;
  out_word_t     out_q;

  logic [HW+1:0] l_idx, r_idx;
  logic [HW:0]   par_idx;
  logic [NW-1:0] last_node;
  logic [CW-1:0] hc_dec;
  logic [HW:0]   best;
  logic          go_l, go_r;
  logic [HW:0]   bld_start, bld_dec;
  logic          pop_leaf, out_load;

  assign l_idx   = {at_q, 1'b1};
  assign r_idx   = {at_q, 1'b0} + (HW+2)'(2);
  assign par_idx = (at_q - (HW+1)'(1)) >> 1;
  assign hc_dec  = heap_cnt_q - CW'(1);
  assign last_node = heap_q[hc_dec[HW-1:0]];
  assign bld_start = (leaf_cnt_q >= CW'(2)) ? (HW+1)'((leaf_cnt_q - CW'(2)) >> 1) : '0;
  assign bld_dec   = bld_q - (HW+1)'(1);
  assign pop_leaf  = (NW+1)'(pop_node_q) < (NW+1)'(leaf_cnt_q);
  assign out_load  = (cmd_i == CMD_WALK_EX) && pop_leaf;

  // Sift compare: pick smaller child with strict compares, left first.
  // wa_q holds the weight of the node being sifted; it stays put while
  // that node moves down, so only the two children are read per step.
  always_comb begin
    go_l = lok_q && (wl_q < wa_q);
    go_r = rok_q && (wr_q < (go_l ? wl_q : wa_q));
    best = go_r ? r_idx[HW:0] : (go_l ? l_idx[HW:0] : at_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_cnt_q <= '0;
      heap_cnt_q <= '0;
      out_v_q    <= 1'b0;
      stk_sp_q   <= '0;
      build_q    <= 1'b0;
      take2_q    <= 1'b0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (cmd_i)
        CMD_LOAD: begin
          if (leaf_cnt_q < CW'(MaxSym)) begin
            sym_mem[leaf_cnt_q[HW-1:0]] <= in_word_i.symbol;
            weight_mem[NW'(leaf_cnt_q)] <= WW'(in_word_i.frequency) & FMask;
            heap_q[leaf_cnt_q[HW-1:0]]  <= NW'(leaf_cnt_q);
            leaf_cnt_q <= leaf_cnt_q + CW'(1);
          end
        end
        CMD_INIT: begin
          heap_cnt_q <= leaf_cnt_q;
          next_q     <= (NW+1)'(leaf_cnt_q);
          at_q       <= bld_start;
          bld_q      <= bld_start;
          // slots below the build point still hold their own leaf
          wa_q       <= weight_mem[NW'(bld_start)];
          build_q    <= 1'b1;
          take2_q    <= 1'b0;
        end
        CMD_SIFT_RD: begin
          lok_q <= (CW+1)'(l_idx) < (CW+1)'(heap_cnt_q);
          rok_q <= (CW+1)'(r_idx) < (CW+1)'(heap_cnt_q);
          wl_q  <= weight_mem[heap_q[l_idx[HW-1:0]]];
          wr_q  <= weight_mem[heap_q[r_idx[HW-1:0]]];
        end
        CMD_SIFT_EX: begin
          if (best != at_q) begin
            heap_q[best[HW-1:0]] <= heap_q[at_q[HW-1:0]];
            heap_q[at_q[HW-1:0]] <= heap_q[best[HW-1:0]];
            at_q <= best;
          end else if (build_q && bld_q != '0) begin
            at_q  <= bld_dec;
            bld_q <= bld_dec;
            wa_q  <= weight_mem[NW'(bld_dec)];
          end else begin
            build_q <= 1'b0;
          end
        end
        CMD_TAKE: begin
          if (take2_q) b_q <= heap_q[0];
          else a_q <= heap_q[0];
          take2_q    <= !take2_q;
          heap_q[0]  <= last_node;
          wa_q       <= weight_mem[last_node];
          heap_cnt_q <= hc_dec;
          at_q       <= '0;
        end
        CMD_MERGE: begin
          weight_mem[next_q[NW-1:0]] <= weight_mem[a_q] + weight_mem[b_q];
          lchild_mem[next_q[NW-1:0]] <= a_q;
          rchild_mem[next_q[NW-1:0]] <= b_q;
          wa_q       <= weight_mem[a_q] + weight_mem[b_q];
          at_q       <= (HW+1)'(heap_cnt_q);
          heap_cnt_q <= heap_cnt_q + CW'(1);
        end
        CMD_UP_RD: begin
          wl_q <= weight_mem[heap_q[par_idx[HW-1:0]]];
        end
        CMD_UP_EX: begin
          if (at_q != '0 && wa_q < wl_q) begin
            heap_q[at_q[HW-1:0]] <= heap_q[par_idx[HW-1:0]];
            at_q <= par_idx;
          end else begin
            heap_q[at_q[HW-1:0]] <= next_q[NW-1:0];
            next_q <= next_q + (NW+1)'(1);
          end
        end
        CMD_WALK_INIT: begin
          stk_node_q[0] <= heap_q[0];
          stk_code_q[0] <= '0;
          stk_len_q[0]  <= '0;
          stk_sp_q      <= SW'(1);
        end
        CMD_WALK_RD: begin
          pop_node_q <= stk_node_q[stk_sp_q - SW'(1)];
          pop_code_q <= stk_code_q[stk_sp_q - SW'(1)];
          pop_len_q  <= stk_len_q[stk_sp_q - SW'(1)];
          stk_sp_q   <= stk_sp_q - SW'(1);
        end
        CMD_WALK_EX: begin
          if (pop_leaf) begin
            out_q.code_symbol <= sym_mem[pop_node_q[HW-1:0]];
            out_q.code_bits   <= pop_code_q;
            out_q.code_length <= pop_len_q;
            out_q.last_code   <= (stk_sp_q == '0);
          end else if ((SW+1)'(stk_sp_q) + (SW+1)'(2) <= (SW+1)'(MaxSym + 1)) begin
            stk_node_q[stk_sp_q] <= rchild_mem[pop_node_q];
            stk_code_q[stk_sp_q] <= {pop_code_q[CodeBits-2:0], 1'b1};
            stk_len_q[stk_sp_q]  <= pop_len_q + LenBits'(1);
            stk_node_q[stk_sp_q + SW'(1)] <= lchild_mem[pop_node_q];
            stk_code_q[stk_sp_q + SW'(1)] <= {pop_code_q[CodeBits-2:0], 1'b0};
            stk_len_q[stk_sp_q + SW'(1)]  <= pop_len_q + LenBits'(1);
            stk_sp_q <= stk_sp_q + SW'(2);
          end
        end
        CMD_FINISH: begin
          leaf_cnt_q <= '0;
          heap_cnt_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status_o.sift_done   = (best == at_q) && !(build_q && bld_q != '0);
    status_o.build_done  = !build_q;
    status_o.heap_single = (heap_cnt_q <= CW'(1)) || (next_q >= (NW+1)'(NodeN));
    status_o.take_second = take2_q;
    status_o.up_done     = (at_q == '0) || !(wa_q < wl_q);
    status_o.walk_empty  = (stk_sp_q == '0);
    status_o.walk_leaf   = pop_leaf;
    status_o.out_full    = out_v_q && out_stall_i;
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/hcb_ctrl.sv
// Sequencer for load, heap build, merges and code walk.
module hcb_ctrl
  import hcb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_e    cmd_o
);

  typedef enum logic [8:0] {
    ST_LOAD  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_SRD   = 9'b000000100,
    ST_SEX   = 9'b000001000,
    ST_TAKE  = 9'b000010000,
    ST_MERGE = 9'b000100000,
    ST_URD   = 9'b001000000,
    ST_UEX   = 9'b010000000,
    ST_WALK  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   wphase_q, wphase_d;   // 0: pop, 1: expand
  logic   winit_q, winit_d;
  logic   merging_q, merging_d;

  always_comb begin
    state_d = state_q;
    wphase_d = wphase_q;
    winit_d = winit_q;
    merging_d = merging_q;
    cmd_o = CMD_NOP;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o = CMD_LOAD;
          if (in_last_i) state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o = CMD_INIT;
        merging_d = 1'b0;
        state_d = ST_SRD;
      end
      ST_SRD: begin
        cmd_o = CMD_SIFT_RD;
        state_d = ST_SEX;
      end
      ST_SEX: begin
        cmd_o = CMD_SIFT_EX;
        if (!status_i.sift_done) state_d = ST_SRD;
        else if (merging_q && status_i.take_second) state_d = ST_TAKE;
        else if (merging_q) state_d = ST_MERGE;
        else if (status_i.heap_single) begin
          state_d = ST_WALK; winit_d = 1'b1;
        end else begin
          state_d = ST_TAKE; merging_d = 1'b1;
        end
      end
      ST_TAKE: begin
        cmd_o = CMD_TAKE;
        state_d = ST_SRD;
      end
      ST_MERGE: begin
        cmd_o = CMD_MERGE;
        state_d = ST_URD;
      end
      ST_URD: begin
        cmd_o = CMD_UP_RD;
        state_d = ST_UEX;
      end
      ST_UEX: begin
        cmd_o = CMD_UP_EX;
        state_d = ST_URD;
        if (status_i.up_done) begin
          if (status_i.heap_single) begin
            state_d = ST_WALK; winit_d = 1'b1;
          end else state_d = ST_TAKE;
        end
      end
      ST_WALK: begin
        if (winit_q) begin
          cmd_o = CMD_WALK_INIT;
          winit_d = 1'b0;
          wphase_d = 1'b0;
        end else if (!wphase_q) begin
          if (status_i.walk_empty) begin
            cmd_o = CMD_FINISH;
            state_d = ST_LOAD;
          end else if (!status_i.out_full) begin
            cmd_o = CMD_WALK_RD;
            wphase_d = 1'b1;
          end
        end else if (!(status_i.walk_leaf && status_i.out_full)) begin
          cmd_o = CMD_WALK_EX;
          wphase_d = 1'b0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      wphase_q <= 1'b0;
      winit_q <= 1'b0;
      merging_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wphase_q <= wphase_d;
      winit_q <= winit_d;
      merging_q <= merging_d;
    end
  end

endmodule

FILE: hw/rtl/huffman_code_builder.sv
// Huffman code builder top level: controller plus heap/tree datapath.
//
//  channel | valid      | stall      | word
//  in      | in_valid_i | in_stall_o | in_word_i  (symbol, frequency, last_symbol)
//  out     | out_valid_o| out_stall_i| out_word_o (code_symbol, code_bits, length, last)
//
// Symbols load one word per cycle. After the last one the block stalls input
// through init, the heap build (read and exchange per sift step), the merges
// (a take plus sift per extracted node, then a merge and a read and exchange
// per insertion level) and the preorder walk (seed, then pop and expand per
// popped node, then finish). At most two weight reads happen a cycle.
// Reset clears counts and state; the node store holds garbage until loaded.
// A stalled output word holds the walk in place; input reopens after the walk
// even while the last code word still waits.
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 32,
  parameter int unsigned FREQ_BITS   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  cmd_e    cmd;
  status_t status;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_symbol),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  hcb_datapath #(
    .MaxSym   (MAX_SYMBOLS),
    .FreqBits (FREQ_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // A stalled code word keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o)) else $error("output changed");

  // A stalled code word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("output dropped");

endmodule

FILE: verif/tb.sv
// Testbench for huffman_code_builder: directed table, then random symbol sets.
`timescale 1ns / 1ps

module tb;
  import hcb_pkg::*;

  localparam int unsigned NSYM  = 32;
  localparam int unsigned NNODE = 2 * NSYM - 1;
  localparam int unsigned LIMIT = 1000000;
  localparam int unsigned HOLD  = 300;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  huffman_code_builder uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Predictor state: tree store, heap and walk stack.
  int unsigned   node_w [NNODE];
  int unsigned   kid_l  [NNODE];
  int unsigned   kid_r  [NNODE];
  bit            is_leaf[NNODE];
  logic [7:0]    leaf_sym[NSYM];
  int unsigned   heap   [NSYM];
  int unsigned   heap_n, leaf_n;
  int unsigned   stk_node[NSYM+1];
  longint unsigned stk_code[NSYM+1];
  int unsigned   stk_dep[NSYM+1];

  out_word_t code_q[$];    // codes still owed by the block
  out_word_t fresh_q[$];   // codes from the latest closing word
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic bit lighter(int unsigned a, int unsigned b);
    return node_w[heap[a]] < node_w[heap[b]];
  endfunction

  function automatic void sift_down(int unsigned at);
    int unsigned best, l, r, t;
    while (1) begin
      best = at;
      l = 2 * at + 1;
      r = 2 * at + 2;
      if (l < heap_n && lighter(l, best)) best = l;
      if (r < heap_n && lighter(r, best)) best = r;
      if (best == at) return;
      t = heap[best];
      heap[best] = heap[at];
      heap[at] = t;
      at = best;
    end
  endfunction

  function automatic int unsigned take_min();
    int unsigned top;
    top = heap[0];
    heap_n--;
    heap[0] = heap[heap_n];
    sift_down(0);
    return top;
  endfunction

  function automatic void put_node(int unsigned node);
    int unsigned i;
    i = heap_n;
    heap_n++;
    while (i != 0 && node_w[node] < node_w[heap[(i-1)/2]]) begin
      heap[i] = heap[(i-1)/2];
      i = (i - 1) / 2;
    end
    heap[i] = node;
  endfunction

  // Loads one word; on the closing word fills fresh_q with the leaf codes.
  function automatic void build_codes(in_word_t w);
    int unsigned n, nxt, a, b, sp, nd, d, i;
    longint unsigned c;
    out_word_t o;
    fresh_q.delete();
    if (leaf_n < NSYM) begin
      leaf_sym[leaf_n] = w.symbol;
      node_w[leaf_n]   = 32'(w.frequency);
      is_leaf[leaf_n]  = 1'b1;
      leaf_n++;
    end
    if (!w.last_symbol) return;
    n = leaf_n;
    for (i = 0; i < n; i++) heap[i] = i;
    heap_n = n;
    i = (n >= 2) ? (n - 2) / 2 + 1 : 1;
    while (i > 0) begin
      i--;
      sift_down(i);
    end
    nxt = n;
    while (heap_n > 1 && nxt < NNODE) begin
      a = take_min();
      b = take_min();
      node_w[nxt]  = node_w[a] + node_w[b];
      kid_l[nxt]   = a;
      kid_r[nxt]   = b;
      is_leaf[nxt] = 1'b0;
      put_node(nxt);
      nxt++;
    end
    // preorder walk, left branch pushed last so it pops first
    stk_node[0] = heap[0];
    stk_code[0] = 0;
    stk_dep[0]  = 0;
    sp = 1;
    while (sp > 0) begin
      sp--;
      nd = stk_node[sp];
      c  = stk_code[sp];
      d  = stk_dep[sp];
      if (is_leaf[nd]) begin
        o.code_symbol = leaf_sym[nd];
        o.code_bits   = c[30:0];
        o.code_length = d[4:0];
        o.last_code   = 1'b0;
        fresh_q.push_back(o);
      end else if (sp + 2 <= NSYM + 1) begin
        stk_node[sp] = kid_r[nd]; stk_code[sp] = (c << 1) | 1; stk_dep[sp] = d + 1;
        sp++;
        stk_node[sp] = kid_l[nd]; stk_code[sp] = c << 1;       stk_dep[sp] = d + 1;
        sp++;
      end
    end
    if (fresh_q.size() > 0) fresh_q[fresh_q.size()-1].last_code = 1'b1;
    leaf_n = 0;
    heap_n = 0;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Directed stimulus. A row sends reps words with the symbol counting up;
  // last_symbol rides only on the final one. Typed rows carry their code.
  typedef struct {
    logic [7:0]  sym;
    logic [15:0] freq;
    bit          last;
    int unsigned reps;
    bit          typed;
    out_word_t   code;
  } row_t;

  row_t dir_tab[] = '{
    // lone symbols: zero-length code
    '{8'hAB, 16'h0000, 1'b1, 1,  1'b1, '{8'hAB, 31'd0, 5'd0, 1'b1}},
    '{8'hFF, 16'hFFFF, 1'b1, 1,  1'b1, '{8'hFF, 31'd0, 5'd0, 1'b1}},
    // pair at the frequency extremes
    '{8'h00, 16'hFFFF, 1'b0, 1,  1'b0, '0},
    '{8'h01, 16'h0000, 1'b1, 1,  1'b0, '0},
    // full set, all ties
    '{8'h10, 16'h0001, 1'b1, 32, 1'b0, '0},
    // full set at max weight: largest sums
    '{8'hE0, 16'hFFFF, 1'b1, 32, 1'b0, '0},
    // over capacity: extra words dropped, closing word still starts build
    '{8'h40, 16'h0007, 1'b1, 35, 1'b0, '0},
    // zero weights
    '{8'h55, 16'h0000, 1'b1, 5,  1'b0, '0},
    // skewed weights: deepest codes
    '{8'h80, 16'h0001, 1'b0, 1,  1'b0, '0},
    '{8'h81, 16'h0002, 1'b0, 1,  1'b0, '0},
    '{8'h82, 16'h0004, 1'b0, 1,  1'b0, '0},
    '{8'h83, 16'h0008, 1'b0, 1,  1'b0, '0},
    '{8'h84, 16'h0010, 1'b1, 1,  1'b0, '0}
  };

  // Drives one word from a falling edge; returns at the falling edge after it
  // is taken.
  task automatic send_word(in_word_t w, bit typed, out_word_t code);
    bit taken;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do begin
      #0.5;
      taken = !in_stall_o;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end while (!taken);
    build_codes(w);
    if (typed) code_q.push_back(code);
    else foreach (fresh_q[k]) code_q.push_back(fresh_q[k]);
    @(negedge clk);
    in_valid_i = 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off, compare on accept.
  initial begin
    int unsigned hold_cnt, burst;
    out_word_t want;
    hold_cnt = 0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 10);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
      #0.5;
      if (out_valid_o && !out_stall_i) begin
        if (code_q.size() == 0) begin
          $display("%0t ns: unexpected code word, expected none, got %0h",
                   $realtime, out_word_o);
          errors++;
        end else begin
          want = code_q.pop_front();
          check_field("code_symbol", 32'(want.code_symbol), 32'(out_word_o.code_symbol));
          check_field("code_bits",   32'(want.code_bits),   32'(out_word_o.code_bits));
          check_field("code_length", 32'(want.code_length), 32'(out_word_o.code_length));
          check_field("last_code",   32'(want.last_code),   32'(out_word_o.last_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    int unsigned sent, n, mode;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    leaf_n = 0;
    heap_n = 0;
    @(negedge clk);

    foreach (dir_tab[r]) begin
      for (int unsigned k = 0; k < dir_tab[r].reps; k++) begin
        w.symbol      = dir_tab[r].sym + k[7:0];
        w.frequency   = dir_tab[r].freq;
        w.last_symbol = dir_tab[r].last && (k == dir_tab[r].reps - 1);
        send_word(w, dir_tab[r].typed, dir_tab[r].code);
      end
    end

    // long hold-off on the result side while sets keep coming
    hold_req = 1'b1;
    sent = 0;
    while (sent < 130) begin
      if (sent > 100) quiet = 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 8);
      mode = $urandom_range(0, 2);
      for (int unsigned k = 0; k < n; k++) begin
        w.symbol      = 8'($urandom_range(0, 255));
        w.frequency   = (mode == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
        w.last_symbol = (k == n - 1);
        send_word(w, 1'b0, '0);
        sent++;
      end
    end

    while (code_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/hcb_pkg.sv
hw/rtl/hcb_datapath.sv
hw/rtl/hcb_ctrl.sv
hw/rtl/huffman_code_builder.sv
verif/tb.sv
